// ----- rtl/core/spwm_pkg.sv -----
// Shared types, widths and constants for the servo pulse generator.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package spwm_pkg;

  // Timer and field widths
  localparam int TIMER_W   = 16;
  localparam int CMP_W     = 16;
  localparam int FREQ_W    = 21;
  localparam int DUTY_W    = 14;
  localparam int DEG_W     = 8;
  localparam int ANGLE_W   = 8;
  localparam int BYTE_W    = 8;
  localparam int PRE_W     = 8;
  localparam int SEL_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Conversion datapath widths
  localparam int DUTYS_W = 25;               // signed duty * degrees
  localparam int DEN_W   = 22;               // degrees * 10000
  localparam int NUM_W   = TIMER_W + 26;     // signed (top + 1) * duty
  localparam int CLK_W   = 24;
  localparam int DVS_W   = FREQ_W + 8;       // frequency times largest prescaler
  localparam int DVD_W   = (NUM_W - 1 > CLK_W) ? NUM_W - 1 : CLK_W;
  localparam int DIVCNT_W = $clog2(DVD_W);
  localparam int EQ_W    = (TIMER_W > CMP_W) ? TIMER_W : CMP_W;

  localparam longint unsigned TopMaxInt   = (64'd1 << TIMER_W) - 64'd1;
  localparam longint unsigned TopResetInt = (64'd4999 > TopMaxInt) ? TopMaxInt : 64'd4999;
  localparam logic [TIMER_W-1:0] TOP_MAX   = TIMER_W'(TopMaxInt);
  localparam logic [TIMER_W-1:0] TOP_RESET = TIMER_W'(TopResetInt);
  localparam logic [DVD_W-1:0]   TOP_LIMIT = DVD_W'(TopMaxInt + 64'd1);
  localparam logic [DVD_W-1:0]   CMP_LIMIT = DVD_W'(64'd65536);
  localparam logic [CMP_W-1:0]   CMP_MAX   = '1;

  localparam logic [CLK_W-1:0]   CLOCK_HZ   = CLK_W'(16000000);
  localparam logic [FREQ_W-1:0]  FAST_LIMIT = FREQ_W'(100000);
  localparam logic [FREQ_W-1:0]  SLOW_LIMIT = FREQ_W'(4);
  localparam logic [BYTE_W-1:0]  NEWLINE    = 8'h0A;
  localparam logic [BYTE_W-1:0]  DIGIT_ZERO = 8'h30;
  localparam logic [13:0]        DUTY_SCALE = 14'd10000;

  // Register reset values
  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(50);
  localparam logic [DUTY_W-1:0] MIN_RESET  = DUTY_W'(275);
  localparam logic [DUTY_W-1:0] MAX_RESET  = DUTY_W'(1275);
  localparam logic [DEG_W-1:0]  DEG_RESET  = DEG_W'(180);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] IDX_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_DEG  = 2'd3;

  // Prescaler selects
  localparam logic [SEL_W-1:0] SEL_DIV8   = 2'd0;
  localparam logic [SEL_W-1:0] SEL_DIV64  = 2'd1;
  localparam logic [SEL_W-1:0] SEL_DIV256 = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUTY,
    ST_NUM,
    ST_CSTART,
    ST_CDIV,
    ST_CLOAD,
    ST_PSTART,
    ST_PDIV,
    ST_PLOAD
  } ctrl_state_e;

  typedef struct packed {
    logic in_ready;
    logic cfg_ready;
    logic accept;
    logic cfg_fire;
    logic ld_duty;
    logic ld_num;
    logic div_start;
    logic div_period;
    logic ld_compare;
    logic ld_period;
  } cmd_t;

  typedef struct packed {
    logic newline;
    logic cfg_freq;
    logic out_blocked;
    logic div_done;
  } stat_t;

  // Last prescaler count before the timer advances
  function automatic logic [PRE_W-1:0] pre_limit(input logic [SEL_W-1:0] sel);
    logic [PRE_W-1:0] lim;
    case (sel)
      SEL_DIV8:  lim = PRE_W'(7);
      SEL_DIV64: lim = PRE_W'(63);
      default:   lim = PRE_W'(255);
    endcase
    return lim;
  endfunction

endpackage

// ----- rtl/core/servo_pwm_from_ascii_angle_top.sv -----
// Top level of the servo pulse generator driven by ASCII angle bytes.
// Depends on spwm_pkg, spwm_ctrl, spwm_dp (and spwm_div below it).
`timescale 1ns / 1ps

// Usage:
// - Input channel (in_valid_i / in_stall_o): each beat is one 16 MHz tick
//   (action_i = 0) or one received byte (action_i = 1, rx_byte_i).
// - Output channel (out_valid_o / out_stall_i): one beat per input beat with
//   the pulse level, compare value in force, accumulated angle and a flag set
//   when a newline loaded a new compare value.
// - Config channel (cfg_valid_i / cfg_ready_o): index 0 frequency, 1 min duty,
//   2 max duty, 3 full-scale degrees. A pending write holds off input beats.
// - Ticks and digit bytes: a new beat is taken every cycle unless the input is
//   stalled, and its result is registered, out in the cycle after acceptance.
// - A newline runs the compare conversion: duty product, period product and a
//   bit-serial division in the shared divider (one quotient bit per cycle,
//   DVD_W = 41 steps); its result beat is pushed when the compare value loads.
// - A frequency write reruns the period derivation through the same divider;
//   input and config stay stalled meanwhile.
// - Reset loads the default registers (50 Hz, /64, top 4999) and clears the
//   counters, the compare value, the level and the angle.
// - When the receiver stalls, the output beat holds and the input stalls once
//   the output register is full and not being taken.
module servo_pwm_from_ascii_angle_top import spwm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 action_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 pwm_level_o,
  output logic [CMP_W-1:0]     pulse_compare_o,
  output logic [ANGLE_W-1:0]   angle_value_o,
  output logic                 position_loaded_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FREQ_W-1:0]    cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence conversions and gate both handshakes
  spwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cfg_valid_i (cfg_valid_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold the datapath state, the divider and the output beat register
  spwm_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .action_i          (action_i),
    .rx_byte_i         (rx_byte_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .pwm_level_o       (pwm_level_o),
    .pulse_compare_o   (pulse_compare_o),
    .angle_value_o     (angle_value_o),
    .position_loaded_o (position_loaded_o)
  );

  assign in_stall_o  = ~cmd.in_ready;
  assign cfg_ready_o = cmd.cfg_ready;

endmodule

// ----- rtl/core/spwm_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on spwm_pkg for operand widths.
`timescale 1ns / 1ps

module spwm_div import spwm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DIVCNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]    rem_q, rem_d;
  logic [DVD_W-1:0]    quo_q, quo_d;
  logic [DVS_W-1:0]    dvs_q, dvs_d;
  logic [DVS_W:0]      shifted;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, quo_q[DVD_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = DVS_W'(shifted - {1'b0, dvs_q});
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIVCNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/core/spwm_dp.sv -----
// Datapath: registers, timer, angle folding, compare conversion, output beat.
// Depends on spwm_pkg and spwm_div.
`timescale 1ns / 1ps

module spwm_dp import spwm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  input  logic                 action_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FREQ_W-1:0]    cfg_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 pwm_level_o,
  output logic [CMP_W-1:0]     pulse_compare_o,
  output logic [ANGLE_W-1:0]   angle_value_o,
  output logic                 position_loaded_o
);

  logic [FREQ_W-1:0]  freq_q, freq_d;
  logic [DUTY_W-1:0]  min_q, min_d;
  logic [DUTY_W-1:0]  max_q, max_d;
  logic [DEG_W-1:0]   deg_q, deg_d;
  logic [SEL_W-1:0]   sel_q, sel_d;
  logic [TIMER_W-1:0] top_q, top_d;
  logic [PRE_W-1:0]   pre_q, pre_d;
  logic [TIMER_W-1:0] tmr_q, tmr_d;
  logic [CMP_W-1:0]   cmp_q, cmp_d;
  logic               lvl_q, lvl_d;
  logic [ANGLE_W-1:0] ang_q, ang_d;

  logic signed [DUTYS_W-1:0] duty_q, duty_d;
  logic [DEN_W-1:0]          den_q, den_d;
  logic signed [NUM_W-1:0]   num_q, num_d;

  logic               out_valid_q, out_valid_d;
  logic               out_lvl_q, out_lvl_d;
  logic [CMP_W-1:0]   out_cmp_q, out_cmp_d;
  logic [ANGLE_W-1:0] out_ang_q, out_ang_d;
  logic               out_ld_q, out_ld_d;

  logic               is_tick, push;
  logic [TIMER_W-1:0] tmr_nxt;
  logic [DEG_W-1:0]   deg_eff;
  logic [21:0]        min_deg;
  logic signed [14:0] span;
  logic signed [23:0] ang_span;
  logic [TIMER_W:0]   top_p1;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic [DVS_W-1:0]   freq_ext;
  logic [DVD_W-1:0]   quo;
  logic               div_done;
  logic [ANGLE_W-1:0] ang_fold;

  spwm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Divider operands: period derivation or compare conversion
  always_comb begin
    freq_ext = DVS_W'(freq_q);
    case (sel_q)
      SEL_DIV8:  dvs = freq_ext << 3;
      SEL_DIV64: dvs = freq_ext << 6;
      default:   dvs = freq_ext << 8;
    endcase
    if (cmd_i.div_period) begin
      dvd = DVD_W'(CLOCK_HZ);
    end else begin
      dvd = DVD_W'(num_q[NUM_W-2:0]);
      dvs = DVS_W'(den_q);
    end
  end

  // Conversion operands
  always_comb begin
    deg_eff  = (deg_q == '0) ? DEG_W'(1) : deg_q;
    min_deg  = 22'(min_q) * 22'(deg_eff);
    span     = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
    ang_span = $signed({1'b0, ang_q}) * span;
    top_p1   = {1'b0, top_q} + 1'b1;
    duty_d   = $signed({3'b000, min_deg}) + $signed({ang_span[23], ang_span});
    den_d    = 22'(deg_eff) * 22'(DUTY_SCALE);
    num_d    = $signed({1'b0, top_p1}) * duty_q;
  end

  always_comb begin
    ang_fold = ({ang_q[ANGLE_W-4:0], 3'b000} + {ang_q[ANGLE_W-2:0], 1'b0})
               + rx_byte_i - DIGIT_ZERO;
    tmr_nxt  = (tmr_q == top_q) ? '0 : tmr_q + 1'b1;
  end

  assign is_tick = ~action_i;
  assign push    = (cmd_i.accept & ~stat_o.newline) | cmd_i.ld_compare;

  // State update
  always_comb begin
    freq_d = freq_q;
    min_d  = min_q;
    max_d  = max_q;
    deg_d  = deg_q;
    sel_d  = sel_q;
    top_d  = top_q;
    pre_d  = pre_q;
    tmr_d  = tmr_q;
    cmp_d  = cmp_q;
    lvl_d  = lvl_q;
    ang_d  = ang_q;

    if (cmd_i.cfg_fire) begin
      case (cfg_index_i)
        IDX_FREQ: begin
          freq_d = cfg_data_i;
          if (cfg_data_i < SLOW_LIMIT) begin
            sel_d = SEL_DIV256;
          end else if (cfg_data_i > FAST_LIMIT) begin
            sel_d = SEL_DIV8;
          end else begin
            sel_d = SEL_DIV64;
          end
        end
        IDX_MIN: min_d = cfg_data_i[DUTY_W-1:0];
        IDX_MAX: max_d = cfg_data_i[DUTY_W-1:0];
        IDX_DEG: deg_d = cfg_data_i[DEG_W-1:0];
        default: ;
      endcase
    end

    if (cmd_i.accept) begin
      if (is_tick) begin
        if (pre_q >= pre_limit(sel_q)) begin
          pre_d = '0;
          tmr_d = tmr_nxt;
          if (EQ_W'(tmr_nxt) == EQ_W'(cmp_q)) begin
            lvl_d = 1'b0;
          end else if (tmr_nxt == top_q) begin
            lvl_d = 1'b1;
          end
        end else begin
          pre_d = pre_q + 1'b1;
        end
      end else if (!stat_o.newline) begin
        ang_d = ang_fold;
      end
    end

    // Floor quotient minus one, clamped to the compare range
    if (cmd_i.ld_compare) begin
      ang_d = '0;
      if (num_q[NUM_W-1] || quo == '0) begin
        cmp_d = '0;
      end else if (quo > CMP_LIMIT) begin
        cmp_d = CMP_MAX;
      end else begin
        cmp_d = CMP_W'(quo - 1'b1);
      end
    end

    if (cmd_i.ld_period) begin
      if (freq_q == '0) begin
        top_d = TOP_MAX;
      end else if (quo == '0) begin
        top_d = '0;
      end else if (quo > TOP_LIMIT) begin
        top_d = TOP_MAX;
      end else begin
        top_d = TIMER_W'(quo - 1'b1);
      end
    end
  end

  // Output beat register
  always_comb begin
    out_valid_d = push | (out_valid_q & out_stall_i);
    out_lvl_d   = out_lvl_q;
    out_cmp_d   = out_cmp_q;
    out_ang_d   = out_ang_q;
    out_ld_d    = out_ld_q;
    if (push) begin
      out_lvl_d = lvl_d;
      out_cmp_d = cmp_d;
      out_ang_d = ang_d;
      out_ld_d  = cmd_i.ld_compare;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q      <= FREQ_RESET;
      min_q       <= MIN_RESET;
      max_q       <= MAX_RESET;
      deg_q       <= DEG_RESET;
      sel_q       <= SEL_DIV64;
      top_q       <= TOP_RESET;
      pre_q       <= '0;
      tmr_q       <= '0;
      cmp_q       <= '0;
      lvl_q       <= 1'b0;
      ang_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      freq_q      <= freq_d;
      min_q       <= min_d;
      max_q       <= max_d;
      deg_q       <= deg_d;
      sel_q       <= sel_d;
      top_q       <= top_d;
      pre_q       <= pre_d;
      tmr_q       <= tmr_d;
      cmp_q       <= cmp_d;
      lvl_q       <= lvl_d;
      ang_q       <= ang_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_duty) begin
      duty_q <= duty_d;
      den_q  <= den_d;
    end
    if (cmd_i.ld_num) begin
      num_q <= num_d;
    end
    out_lvl_q <= out_lvl_d;
    out_cmp_q <= out_cmp_d;
    out_ang_q <= out_ang_d;
    out_ld_q  <= out_ld_d;
  end

  assign stat_o.newline     = action_i & (rx_byte_i == NEWLINE);
  assign stat_o.cfg_freq    = (cfg_index_i == IDX_FREQ);
  assign stat_o.out_blocked = out_valid_q & out_stall_i;
  assign stat_o.div_done    = div_done;

  assign out_valid_o       = out_valid_q;
  assign pwm_level_o       = out_lvl_q;
  assign pulse_compare_o   = out_cmp_q;
  assign angle_value_o     = out_ang_q;
  assign position_loaded_o = out_ld_q;

endmodule

// ----- rtl/core/spwm_ctrl.sv -----
// Controller: sequences compare conversion and period derivation.
// Depends on spwm_pkg for the state enum and command/status structs.
`timescale 1ns / 1ps

module spwm_ctrl import spwm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  cfg_valid_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.cfg_fire && stat_i.cfg_freq) begin
          state_d = ST_PSTART;
        end else if (cmd_o.accept && stat_i.newline) begin
          state_d = ST_DUTY;
        end
      end
      ST_DUTY:   state_d = ST_NUM;
      ST_NUM:    state_d = ST_CSTART;
      ST_CSTART: state_d = ST_CDIV;
      ST_CDIV:   if (stat_i.div_done) state_d = ST_CLOAD;
      ST_CLOAD:  state_d = ST_IDLE;
      ST_PSTART: state_d = ST_PDIV;
      ST_PDIV:   if (stat_i.div_done) state_d = ST_PLOAD;
      ST_PLOAD:  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        // configuration takes priority over items
        cmd_o.cfg_ready = 1'b1;
        cmd_o.in_ready  = ~stat_i.out_blocked & ~cfg_valid_i;
        cmd_o.accept    = in_valid_i & cmd_o.in_ready;
        cmd_o.cfg_fire  = cfg_valid_i;
      end
      ST_DUTY:   cmd_o.ld_duty = 1'b1;
      ST_NUM:    cmd_o.ld_num = 1'b1;
      ST_CSTART: cmd_o.div_start = 1'b1;
      ST_CLOAD:  cmd_o.ld_compare = 1'b1;
      ST_PSTART: begin
        cmd_o.div_start  = 1'b1;
        cmd_o.div_period = 1'b1;
      end
      ST_PLOAD:  cmd_o.ld_period = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
